// ===== src/pbd_pkg.sv =====
// Shared constants and types for the Poisson-binomial distribution unit.
package pbd_pkg;

	// Default longest run that is tracked, and default fraction bits of a value.
	localparam int MAX_COUNT_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	// Default field widths that follow from the defaults above.
	localparam int PROB_W_DEF  = FRAC_BITS_DEF + 1;
	localparam int COUNT_W_DEF = $clog2(MAX_COUNT_DEF + 1);

	// Per-cycle command broadcast to every cell of the weight chain.
	typedef struct packed {
		logic update;   // apply one probability to every weight
		logic shift;    // move every weight one cell toward cell zero
		logic restart;  // return to the empty distribution
	} pbd_cell_ctl_t;

endpackage

// ===== src/pbd_in_if.sv =====
// Input channel carrying one success probability per beat.
interface pbd_in_if import pbd_pkg::*; #(
	parameter int PROB_W = PROB_W_DEF
) ();
	logic              valid;
	logic              ready;
	logic [PROB_W-1:0] prob;
	logic              last_prob;
	logic              empty_run;

	modport source (output valid, prob, last_prob, empty_run, input ready);
	modport sink (input valid, prob, last_prob, empty_run, output ready);
endinterface

// ===== src/pbd_out_if.sv =====
// Output channel carrying one weight of the distribution per beat.
interface pbd_out_if import pbd_pkg::*; #(
	parameter int COUNT_W  = COUNT_W_DEF,
	parameter int WEIGHT_W = PROB_W_DEF
) ();
	logic                valid;
	logic                ready;
	logic [COUNT_W-1:0]  success_count;
	logic [WEIGHT_W-1:0] weight;
	logic                last_weight;

	modport source (output valid, success_count, weight, last_weight, input ready);
	modport sink (input valid, success_count, weight, last_weight, output ready);
endinterface

// ===== src/pbd_cell.sv =====
// One cell of the weight chain: holds a single weight and mixes in its lower neighbor.
module pbd_cell import pbd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter bit IS_BOTTOM = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pbd_cell_ctl_t        ctl,
	input  logic [FRAC_BITS:0]   prob,
	input  logic [FRAC_BITS:0]   lower,
	input  logic [FRAC_BITS:0]   upper,
	output logic [FRAC_BITS:0]   weight
);
	localparam int WW   = FRAC_BITS + 1;
	localparam int AW   = 2 * WW + 2;
	localparam int RW   = AW - FRAC_BITS;
	localparam int PADW = AW - WW - FRAC_BITS;

	localparam logic [WW-1:0]        ONE_W   = WW'(1) << FRAC_BITS;
	localparam logic [WW-1:0]        RESET_W = IS_BOTTOM ? ONE_W : '0;
	localparam logic [RW-1:0]        ONE_R   = RW'(1) << FRAC_BITS;
	localparam logic signed [AW-1:0] HALF    = AW'(1) << (FRAC_BITS - 1);

	logic [WW-1:0]        w_q;
	logic signed [WW:0]   diff;
	logic signed [AW-1:0] prod;
	logic signed [AW-1:0] acc;
	logic [RW-1:0]        rnd;
	logic [WW-1:0]        mixed;

	// q*w + p*lower equals one*w + p*(lower - w) exactly, so a single
	// signed product gives the same rounded result.
	assign diff  = $signed({1'b0, lower}) - $signed({1'b0, w_q});
	assign prod  = $signed({1'b0, prob}) * diff;
	assign acc   = $signed({{PADW{1'b0}}, w_q, {FRAC_BITS{1'b0}}}) + prod + HALF;
	assign rnd   = acc[AW-1:FRAC_BITS];
	assign mixed = (rnd > ONE_R) ? ONE_W : rnd[WW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= RESET_W;
		end else if (ctl.restart) begin
			w_q <= RESET_W;
		end else if (ctl.shift) begin
			w_q <= upper;
		end else if (ctl.update) begin
			w_q <= mixed;
		end
	end

	assign weight = w_q;

endmodule

// ===== src/poisson_binomial_distribution_unit.sv =====
// Poisson-binomial distribution unit: a chain of weight cells with its run control.
// An input beat updates all weights at its accepting edge, one beat per cycle while no run drains.
// A beat with last_prob or empty_run starts a drain: the first result is valid the next cycle,
// and a run of n probabilities gives min(n, MAX_COUNT)+1 result beats, one per cycle when the sink is ready.
// The input is held off while a run drains; the chain shifts toward cell zero once per non-final result.
// Reset (arst_n low, asynchronous) sets weight zero to one, all other weights and counts to zero.
module poisson_binomial_distribution_unit import pbd_pkg::*; #(
	parameter int MAX_COUNT = MAX_COUNT_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pbd_in_if.sink    in_ch,
	pbd_out_if.source out_ch
);
	localparam int WW = FRAC_BITS + 1;
	localparam int CW = $clog2(MAX_COUNT + 1);

	localparam logic [WW-1:0] ONE_W    = WW'(1) << FRAC_BITS;
	localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_COUNT);

	// Run bookkeeping: probabilities folded in so far, drain state, the index of
	// the weight on the output and the index of the final weight of the run.
	logic [CW-1:0] items_q;
	logic          drain_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] n_q;

	logic          in_fire;
	logic          out_fire;
	logic          final_beat;
	logic          can_grow;
	logic [CW-1:0] items_next;
	logic [WW-1:0] prob_sat;
	pbd_cell_ctl_t ctl;

	// Weight of every cell; the zeros below cell zero and above the top cell are fed in by the chain.
	logic [WW-1:0] w [0:MAX_COUNT];

	assign in_ch.ready = !drain_q;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_fire    = out_ch.valid && out_ch.ready;
	assign final_beat  = (idx_q == n_q);

	// A probability above one counts as one.
	assign prob_sat = (in_ch.prob > ONE_W) ? ONE_W : in_ch.prob;

	// Once the run is as long as the chain, later probabilities change nothing.
	assign can_grow   = (items_q < MAX_CNT);
	assign items_next = can_grow ? items_q + CW'(1) : items_q;

	// An empty run and the final result beat both return the chain to its
	// reset contents. Cells above the run stay zero, so updating them is harmless.
	always_comb begin
		ctl.restart = (in_fire && in_ch.empty_run) || (out_fire && final_beat);
		ctl.shift   = out_fire && !final_beat;
		ctl.update  = in_fire && !in_ch.empty_run && can_grow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q <= '0;
			drain_q <= 1'b0;
			idx_q   <= '0;
			n_q     <= '0;
		end else if (in_fire) begin
			idx_q <= '0;
			if (in_ch.empty_run) begin
				items_q <= '0;
				drain_q <= 1'b1;
				n_q     <= '0;
			end else begin
				items_q <= items_next;
				drain_q <= in_ch.last_prob;
				n_q     <= items_next;
			end
		end else if (out_fire) begin
			if (final_beat) begin
				items_q <= '0;
				drain_q <= 1'b0;
			end else begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// The chain proper: cell i reads cell i-1 for the update and cell i+1 for the drain.
	for (genvar i = 0; i <= MAX_COUNT; i++) begin : g_cell
		logic [WW-1:0] lower;
		logic [WW-1:0] upper;

		if (i == 0) begin : g_low
			assign lower = '0;
		end else begin : g_low
			assign lower = w[i-1];
		end

		if (i == MAX_COUNT) begin : g_up
			assign upper = '0;
		end else begin : g_up
			assign upper = w[i+1];
		end

		pbd_cell #(
			.FRAC_BITS (FRAC_BITS),
			.IS_BOTTOM (i == 0)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.prob   (prob_sat),
			.lower  (lower),
			.upper  (upper),
			.weight (w[i])
		);
	end

	// The weight under the output always sits in cell zero.
	assign out_ch.valid         = drain_q;
	assign out_ch.success_count = idx_q;
	assign out_ch.weight        = w[0];
	assign out_ch.last_weight   = final_beat;

	// The run length never passes the number of cells above cell zero.
	a_items_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		items_q <= MAX_CNT)
		else $error("run length exceeds the chain");

	// While draining, the output index never passes the final index.
	a_idx_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> (idx_q <= n_q))
		else $error("output index ran past the end of the run");

	// Each non-final result beat is followed by the next count.
	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !final_beat) |=>
			(out_ch.valid && out_ch.success_count == $past(out_ch.success_count) + CW'(1)))
		else $error("success count did not advance by one");

	// After the final beat the unit returns to taking probabilities.
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && final_beat) |=> (in_ch.ready && items_q == '0))
		else $error("unit did not restart after the final weight");

endmodule

// ===== sim/pbd_checker.sv =====
// Scoreboard that predicts and checks the weight beats of the distribution unit.
module pbd_checker import pbd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [PROB_W_DEF-1:0]  in_prob,
	input  logic                   in_last_prob,
	input  logic                   in_empty_run,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [COUNT_W_DEF-1:0] out_success_count,
	input  logic [PROB_W_DEF-1:0]  out_weight,
	input  logic                   out_last_weight,
	output int                     fail_count,
	output int                     pending,
	output int                     probs_seen,
	output int                     weights_seen,
	output int                     runs_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ONE = 1 << FRAC_BITS_DEF;

	typedef logic [PROB_W_DEF-1:0] value_t;

	typedef struct packed {
		logic [COUNT_W_DEF-1:0] count;
		value_t                 weight;
		logic                   last;
	} weight_beat_t;

	weight_beat_t expected_weights[$];
	value_t       weights_model[MAX_COUNT_DEF+1];
	int unsigned  run_len;

	// Weighted sum q*a + p*b back in Q1.16, rounded half up and clipped at one.
	function automatic value_t blend(value_t q, value_t a, value_t p, value_t b);
		logic [35:0] acc;
		acc = 36'(q) * 36'(a) + 36'(p) * 36'(b) + 36'(ONE / 2);
		acc = acc >> FRAC_BITS_DEF;
		return (acc > 36'(ONE)) ? value_t'(ONE) : value_t'(acc);
	endfunction

	task automatic reset_distribution();
		foreach (weights_model[i])
			weights_model[i] = '0;
		weights_model[0] = value_t'(ONE);
		run_len = 0;
	endtask

	// Folds one accepted probability into the distribution and queues the weights it releases.
	task automatic apply_probability(value_t prob, logic last, logic empty);
		weight_beat_t beat;
		value_t       p;
		value_t       q;
		if (empty) begin
			beat.count = '0;
			beat.weight = value_t'(ONE);
			beat.last = 1'b1;
			expected_weights = {expected_weights, beat};
			reset_distribution();
			return;
		end
		p = (prob > value_t'(ONE)) ? value_t'(ONE) : prob;
		q = value_t'(ONE) - p;
		// A run longer than the chain leaves the stored weights untouched.
		if (run_len < MAX_COUNT_DEF) begin
			for (int i = run_len + 1; i > 0; i--)
				weights_model[i] = blend(q, weights_model[i], p, weights_model[i-1]);
			weights_model[0] = blend(q, weights_model[0], p, '0);
			run_len++;
		end
		if (last) begin
			for (int i = 0; i <= run_len; i++) begin
				beat.count = COUNT_W_DEF'(i);
				beat.weight = weights_model[i];
				beat.last = (i == run_len);
				expected_weights = {expected_weights, beat};
			end
			reset_distribution();
		end
	endtask

	task automatic check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	initial begin
		reset_distribution();
		fail_count = 0;
		pending = 0;
		probs_seen = 0;
		weights_seen = 0;
		runs_seen = 0;
	end

	// Results are checked before the input of the same edge is folded in: a result
	// can only belong to a beat accepted at an earlier edge.
	always @(posedge clk) begin
		weight_beat_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				weights_seen++;
				if (out_last_weight)
					runs_seen++;
				if (expected_weights.size() == 0) begin
					$display("%0t ns: unexpected weight beat, count %0d weight %0d last %0b",
						$time, out_success_count, out_weight, out_last_weight);
					fail_count++;
				end else begin
					want = expected_weights.pop_front();
					check_field("success_count", want.count, out_success_count);
					check_field("weight", want.weight, out_weight);
					check_field("last_weight", want.last, out_last_weight);
				end
			end
			if (in_valid && in_ready) begin
				probs_seen++;
				apply_probability(in_prob, in_last_prob, in_empty_run);
			end
			pending = expected_weights.size();
		end
	end

endmodule

// ===== sim/tb_poisson_binomial_distribution_unit.sv =====
// Testbench top: clock, reset, probability stimulus, result backpressure and the verdict.
module tb_poisson_binomial_distribution_unit import pbd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          ONE         = 1 << FRAC_BITS_DEF;
	localparam int          PROB_MAX    = (1 << PROB_W_DEF) - 1;
	localparam int          RANDOM_GOAL = 200;
	// Result beat counts at which the sink stops taking results for a long while.
	localparam int unsigned HOLD_AT_A   = 60;
	localparam int unsigned HOLD_AT_B   = 140;
	localparam int unsigned HOLD_CYCLES = 150;

	logic clk;
	logic arst_n;

	pbd_in_if  in_ch ();
	pbd_out_if out_ch ();

	int fail_count;
	int pending;
	int probs_seen;
	int weights_seen;
	int runs_seen;

	// Beats offered by the stimulus so far; the random part stops on this count.
	int unsigned probs_offered;
	// While set, the sender offers back-to-back beats without idle cycles.
	logic        sender_streaming;

	poisson_binomial_distribution_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	pbd_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_ch.valid),
		.in_ready          (in_ch.ready),
		.in_prob           (in_ch.prob),
		.in_last_prob      (in_ch.last_prob),
		.in_empty_run      (in_ch.empty_run),
		.out_valid         (out_ch.valid),
		.out_ready         (out_ch.ready),
		.out_success_count (out_ch.success_count),
		.out_weight        (out_ch.weight),
		.out_last_weight   (out_ch.last_weight),
		.fail_count        (fail_count),
		.pending           (pending),
		.probs_seen        (probs_seen),
		.weights_seen      (weights_seen),
		.runs_seen         (runs_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs; it leaves a wide margin over the slowest correct run.
	initial begin
		#6_000_000;
		$display("Run timed out with %0d weight beats still outstanding.", pending);
		$display("Mismatches found");
		$finish;
	end

	// Draws a probability. Most are in range; the exact ends of the range and values
	// above one (which the block must clip to one) each get a fair share.
	function automatic logic [PROB_W_DEF-1:0] random_prob();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return PROB_W_DEF'(ONE);
			2:       return PROB_W_DEF'($urandom_range(ONE + 1, PROB_MAX));
			default: return PROB_W_DEF'($urandom_range(0, ONE));
		endcase
	endfunction

	// Offers one input beat after a random number of idle cycles and returns once it
	// is taken. valid is only lowered when there really is a gap, so a beat that
	// follows directly never sees valid dropped and raised in the same time step.
	task automatic send_prob(logic [PROB_W_DEF-1:0] prob, logic last, logic empty);
		int unsigned gap;
		gap = sender_streaming ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.prob <= prob;
		in_ch.last_prob <= last;
		in_ch.empty_run <= empty;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		probs_offered++;
	endtask

	// Sends a well-formed run of len probabilities with last_prob on the final one.
	// When break_at names a position, an empty-run beat goes out there instead and
	// the partial run is thrown away by the block.
	task automatic send_run(int unsigned len, int break_at);
		for (int k = 0; k < len; k++) begin
			if (k == break_at) begin
				send_prob(random_prob(), 1'($urandom_range(0, 1)), 1'b1);
				return;
			end
			send_prob(random_prob(), k == len - 1, 1'b0);
		end
	endtask

	// Result side. Before each result beat it may idle at random, with spells of
	// no idling at all. Twice during the run it refuses results for a long stretch
	// while the sender keeps offering, so the drain stalls and the input backs up.
	initial begin : sink_side
		int unsigned stall;
		int unsigned taken;
		logic        streaming;
		out_ch.ready <= 1'b0;
		taken = 0;
		streaming = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				streaming = !streaming;
			if (taken == HOLD_AT_A || taken == HOLD_AT_B)
				stall = HOLD_CYCLES;
			else
				stall = streaming ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			taken++;
		end
	end

	// Stimulus and verdict.
	initial begin
		int unsigned len;
		int          break_at;
		in_ch.valid <= 1'b0;
		in_ch.prob <= '0;
		in_ch.last_prob <= 1'b0;
		in_ch.empty_run <= 1'b0;
		probs_offered = 0;
		sender_streaming = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. An empty run straight out of reset, with junk in the
		// ignored fields, must give the single weight one.
		send_prob(17'd5, 1'b1, 1'b1);
		// One-probability runs at zero, exactly one, and the all-ones pattern,
		// which lies above one and must be clipped.
		send_prob('0, 1'b1, 1'b0);
		send_prob(PROB_W_DEF'(ONE), 1'b1, 1'b0);
		send_prob(PROB_W_DEF'(PROB_MAX), 1'b1, 1'b0);
		// Smallest step, one half and just below one in a single run.
		send_prob(17'd1, 1'b0, 1'b0);
		send_prob(17'd32768, 1'b0, 1'b0);
		send_prob(17'd65535, 1'b1, 1'b0);
		// A run cut short by an empty run: the partial weights are dropped.
		send_prob(17'd12345, 1'b0, 1'b0);
		send_prob(17'd40000, 1'b0, 1'b0);
		send_prob(PROB_W_DEF'(PROB_MAX), 1'b0, 1'b1);
		// Certain and impossible events mixed, then a fraction; all weight moves
		// into exactly one count before the last beat spreads it.
		send_prob(PROB_W_DEF'(ONE), 1'b0, 1'b0);
		send_prob('0, 1'b0, 1'b0);
		send_prob(PROB_W_DEF'(ONE), 1'b0, 1'b0);
		send_prob(17'd21845, 1'b1, 1'b0);
		// An empty run with last_prob set as well, back to back with the next beat.
		sender_streaming = 1'b1;
		send_prob('0, 1'b1, 1'b1);
		send_prob(17'd50000, 1'b1, 1'b0);
		sender_streaming = 1'b0;

		// A run longer than the chain: the probabilities past the full count are
		// ignored and the drain gives every stored weight.
		send_run(MAX_COUNT_DEF + 2, -1);

		// Random part: mostly short well-formed runs, now and then a long one, a run
		// broken by an empty beat, or a lone empty beat.
		while (probs_offered < RANDOM_GOAL) begin
			sender_streaming = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 11) == 0) begin
				send_prob(random_prob(), 1'($urandom_range(0, 1)), 1'b1);
			end else begin
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(MAX_COUNT_DEF - 2, MAX_COUNT_DEF + 8);
				else
					len = $urandom_range(1, 8);
				break_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
				send_run(len, break_at);
			end
		end
		in_ch.valid <= 1'b0;

		// Let every predicted weight drain, then give a stray late beat time to show.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2 * (MAX_COUNT_DEF + 1)) @(posedge clk);

		$display("Sent %0d probability beats; %0d runs came back as %0d weight beats.",
			probs_seen, runs_seen, weights_seen);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d field mismatches or stray beats.", fail_count);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== poisson_binomial_distribution_unit.f =====
src/pbd_pkg.sv
src/pbd_in_if.sv
src/pbd_out_if.sv
src/pbd_cell.sv
src/poisson_binomial_distribution_unit.sv
sim/pbd_checker.sv
sim/tb_poisson_binomial_distribution_unit.sv
